@@ rtl/core/bvaw_pkg.sv @@
// Shared types and constants for the bricked volume address walker.
`timescale 1ns / 1ps
package bvaw_pkg;

   localparam int MAX_DIM  = 1024;
   localparam int DIM_W    = 11;
   localparam int DIST_W   = 30;
   localparam int LIN_W    = 32;
   localparam int ITER_W   = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] KIND_RESTART = 2'd0;
   localparam logic [1:0] KIND_STEP    = 2'd1;
   localparam logic [1:0] KIND_JUMP    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_DIM_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BRICK_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BRICK_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BRICK_Z = 3'd5;

   // A command after classification: restart, or advance by a node count.
   typedef struct packed {
      logic              restart;
      logic [DIST_W-1:0] adv;
   } cmd_type;

   // Effective geometry, with zero values and oversize dimensions already fixed up.
   typedef struct packed {
      logic [DIM_W-1:0] dx;
      logic [DIM_W-1:0] dy;
      logic [DIM_W-1:0] dz;
      logic [DIM_W-1:0] bx;
      logic [DIM_W-1:0] by;
      logic [DIM_W-1:0] bz;
   } geom_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] eff_brick(input logic [DIM_W-1:0] b);
      return (b == '0) ? DIM_W'(1) : b;
   endfunction

endpackage

@@ rtl/core/bricked_volume_address_walker_unit.sv @@
// Top level of the bricked volume address walker.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tuser: kind; tdata: jump_distance
//   rsp      out        rsp_tvalid/tready    tuser: at_end; tdata: brick, offset, x, y, z
//   csr      in         csr_we               csr_addr, csr_wdata
//
// A step or jump runs seven serial divisions in the shared divider at one bit
// per cycle; a restart runs five, and a move past the last node runs none.
// The front queue holds two commands, so input is taken while one is worked.
// Reset is synchronous; it clears the position, the queue and the output valid.
// A stalled result word holds the back end but not the front queue.
`timescale 1ns / 1ps
module bricked_volume_address_walker_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,  // jump_distance, pad
   input  logic [1:0]                           req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // brick_number, offset_in_brick, pos_x, pos_y, pos_z, pad
   output logic [95:0]                          rsp_tdata,
   output logic                                 rsp_tuser,  // at_end
   input  logic                                 csr_we,
   input  logic [bvaw_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [bvaw_pkg::DIM_W-1:0]           csr_wdata
);
   logic [bvaw_pkg::DIM_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [bvaw_pkg::DIM_W-1:0] brk_x_ff, brk_y_ff, brk_z_ff;
   bvaw_pkg::geom_type         geom;
   bvaw_pkg::cmd_type          cmd;
   logic                       cmd_valid, cmd_pop;
   logic [bvaw_pkg::DIST_W-1:0] bn, off;
   logic [bvaw_pkg::DIM_W-1:0]  px, py, pz;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= bvaw_pkg::DIM_W'(1);
         dim_y_ff <= bvaw_pkg::DIM_W'(1);
         dim_z_ff <= bvaw_pkg::DIM_W'(1);
         brk_x_ff <= bvaw_pkg::DIM_W'(1);
         brk_y_ff <= bvaw_pkg::DIM_W'(1);
         brk_z_ff <= bvaw_pkg::DIM_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            bvaw_pkg::REG_DIM_X:   dim_x_ff <= csr_wdata;
            bvaw_pkg::REG_DIM_Y:   dim_y_ff <= csr_wdata;
            bvaw_pkg::REG_DIM_Z:   dim_z_ff <= csr_wdata;
            bvaw_pkg::REG_BRICK_X: brk_x_ff <= csr_wdata;
            bvaw_pkg::REG_BRICK_Y: brk_y_ff <= csr_wdata;
            bvaw_pkg::REG_BRICK_Z: brk_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      geom.dx = bvaw_pkg::eff_dim(dim_x_ff);
      geom.dy = bvaw_pkg::eff_dim(dim_y_ff);
      geom.dz = bvaw_pkg::eff_dim(dim_z_ff);
      geom.bx = bvaw_pkg::eff_brick(brk_x_ff);
      geom.by = bvaw_pkg::eff_brick(brk_y_ff);
      geom.bz = bvaw_pkg::eff_brick(brk_z_ff);
   end

   bvaw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_dist   (req_tdata[bvaw_pkg::DIST_W-1:0]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   bvaw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_brick  (bn),
      .rsp_offset (off),
      .rsp_x      (px),
      .rsp_y      (py),
      .rsp_z      (pz),
      .rsp_end    (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, pz, py, px, off, bn};
endmodule

@@ rtl/core/bvaw_div.sv @@
// Restoring divider, one quotient bit per cycle, 11-bit divisor.
`timescale 1ns / 1ps
module bvaw_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bvaw_pkg::LIN_W-1:0]        dividend,
   input  logic [bvaw_pkg::DIM_W-1:0]        divisor,
   input  logic [bvaw_pkg::ITER_W-1:0]       iters,
   output logic                              done,
   output logic [bvaw_pkg::LIN_W-1:0]        quot,
   output logic [bvaw_pkg::DIM_W-1:0]        rem
);
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [bvaw_pkg::ITER_W-1:0]       cnt_ff, cnt_in;
   logic [bvaw_pkg::LIN_W-1:0]        dvd_ff, dvd_in;
   logic [bvaw_pkg::LIN_W-1:0]        q_ff, q_in;
   logic [bvaw_pkg::DIM_W-1:0]        r_ff, r_in;
   logic [bvaw_pkg::DIM_W:0]          trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      trial   = {r_ff, dvd_ff[bvaw_pkg::LIN_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         dvd_in  = dividend;
         q_in    = '0;
         r_in    = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            r_in = bvaw_pkg::DIM_W'(trial - {1'b0, divisor});
            q_in = {q_ff[bvaw_pkg::LIN_W-2:0], 1'b1};
         end else begin
            r_in = trial[bvaw_pkg::DIM_W-1:0];
            q_in = {q_ff[bvaw_pkg::LIN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bvaw_pkg::ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;
endmodule

@@ rtl/core/bvaw_front.sv @@
// Front end: accepts command words, classifies them and queues them.
`timescale 1ns / 1ps
module bvaw_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [1:0]                       in_kind,
   input  logic [bvaw_pkg::DIST_W-1:0]      in_dist,
   output logic                             cmd_valid,
   output bvaw_pkg::cmd_type                cmd,
   input  logic                             cmd_pop
);
   bvaw_pkg::cmd_type q_ff [2];
   bvaw_pkg::cmd_type new_cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   always_comb begin
      new_cmd.restart = 1'b0;
      new_cmd.adv     = '0;
      case (in_kind)
         bvaw_pkg::KIND_RESTART: new_cmd.restart = 1'b1;
         bvaw_pkg::KIND_STEP:    new_cmd.adv = bvaw_pkg::DIST_W'(1);
         bvaw_pkg::KIND_JUMP:    new_cmd.adv = in_dist;
         default:                new_cmd.adv = '0;  // unused kind holds position
      endcase
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) q_ff[wr_ptr_ff] <= new_cmd;
   end
endmodule

@@ rtl/core/bvaw_back.sv @@
// Back end: sequencer that moves the position and forms brick addresses.
`timescale 1ns / 1ps
module bvaw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  bvaw_pkg::geom_type               geom,
   input  logic                             cmd_valid,
   input  bvaw_pkg::cmd_type                cmd,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bvaw_pkg::DIST_W-1:0]      rsp_brick,
   output logic [bvaw_pkg::DIST_W-1:0]      rsp_offset,
   output logic [bvaw_pkg::DIM_W-1:0]       rsp_x,
   output logic [bvaw_pkg::DIM_W-1:0]       rsp_y,
   output logic [bvaw_pkg::DIM_W-1:0]       rsp_z,
   output logic                             rsp_end
);
   localparam int W   = bvaw_pkg::DIM_W;
   localparam int LW  = bvaw_pkg::LIN_W;
   localparam int DW  = bvaw_pkg::DIST_W;
   localparam int IW  = bvaw_pkg::ITER_W;
   localparam int AW  = 2 * W;
   localparam int PW  = 3 * W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   typedef enum logic [16:0] {
      S_DXDY = 17'b0_0000_0000_0000_0001,
      S_LZ   = 17'b0_0000_0000_0000_0010,
      S_LY   = 17'b0_0000_0000_0000_0100,
      S_LAST = 17'b0_0000_0000_0000_1000,
      S_DIVX = 17'b0_0000_0000_0001_0000,
      S_DIVY = 17'b0_0000_0000_0010_0000,
      S_XB   = 17'b0_0000_0000_0100_0000,
      S_YB   = 17'b0_0000_0000_1000_0000,
      S_ZB   = 17'b0_0000_0001_0000_0000,
      S_NBX  = 17'b0_0000_0010_0000_0000,
      S_NBY  = 17'b0_0000_0100_0000_0000,
      S_NN   = 17'b0_0000_1000_0000_0000,
      S_BNZ  = 17'b0_0001_0000_0000_0000,
      S_BNY  = 17'b0_0010_0000_0000_0000,
      S_BB   = 17'b0_0100_0000_0000_0000,
      S_OFZ  = 17'b0_1000_0000_0000_0000,
      S_OFY  = 17'b1_0000_0000_0000_0000
   } step_type;

   state_type         state_ff, state_in;
   step_type          step_ff, step_in;
   logic [W-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, cur_z_ff, cur_z_in;
   logic [DW-1:0]     adv_ff, adv_in;
   logic [AW-1:0]     dxdy_ff, dxdy_in;
   logic [LW-1:0]     acc_ff, acc_in;
   logic [AW-1:0]     t_ff, t_in;
   logic [W-1:0]      xq_ff, xq_in, xr_ff, xr_in, yq_ff, yq_in, yr_ff, yr_in;
   logic [W-1:0]      zq_ff, zq_in, zr_ff, zr_in, nbx_ff, nbx_in, nby_ff, nby_in;
   logic [AW-1:0]     nn_ff, nn_in, bb_ff, bb_in;
   logic [DW-1:0]     bn_ff, bn_in, off_ff, off_in;
   logic              end_ff, end_in;
   logic              rv_ff, rv_in;
   logic [DW-1:0]     rb_ff, rb_in, ro_ff, ro_in;
   logic [W-1:0]      rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic              re_ff, re_in;

   logic [AW-1:0]     mul_a;
   logic [W-1:0]      mul_b;
   logic [PW-1:0]     mul_p;
   logic              div_start, div_done;
   logic [LW-1:0]     div_dvd, div_q;
   logic [W-1:0]      div_dsr, div_r;
   logic [IW-1:0]     div_it;

   bvaw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .iters    (div_it),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   // Operand selection for the multiplier and the divider by sequencer step.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      div_dvd = '0;
      div_dsr = W'(1);
      div_it  = IW'(W);
      case (step_ff)
         S_DXDY: begin mul_a = AW'(geom.dx); mul_b = geom.dy; end
         S_LZ:   begin mul_a = dxdy_ff;      mul_b = cur_z_ff; end
         S_LY:   begin mul_a = AW'(geom.dx); mul_b = cur_y_ff; end
         S_LAST: begin mul_a = dxdy_ff;      mul_b = geom.dz; end
         S_DIVX: begin div_dvd = acc_ff; div_dsr = geom.dx; div_it = IW'(LW); end
         S_DIVY: begin
            div_dvd = {t_ff, (LW-AW)'(0)};
            div_dsr = geom.dy;
            div_it  = IW'(AW);
         end
         S_XB:   begin div_dvd = {cur_x_ff, (LW-W)'(0)}; div_dsr = geom.bx; end
         S_YB:   begin div_dvd = {cur_y_ff, (LW-W)'(0)}; div_dsr = geom.by; end
         S_ZB:   begin div_dvd = {cur_z_ff, (LW-W)'(0)}; div_dsr = geom.bz; end
         S_NBX:  begin div_dvd = {geom.dx - 1'b1, (LW-W)'(0)}; div_dsr = geom.bx; end
         S_NBY:  begin div_dvd = {geom.dy - 1'b1, (LW-W)'(0)}; div_dsr = geom.by; end
         S_NN:   begin mul_a = AW'(nbx_ff);  mul_b = nby_ff; end
         S_BNZ:  begin mul_a = nn_ff;        mul_b = zq_ff; end
         S_BNY:  begin mul_a = AW'(nbx_ff);  mul_b = yq_ff; end
         S_BB:   begin mul_a = AW'(geom.bx); mul_b = geom.by; end
         S_OFZ:  begin mul_a = bb_ff;        mul_b = zr_ff; end
         S_OFY:  begin mul_a = AW'(geom.bx); mul_b = yr_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   assign div_start = (state_ff == ST_RUN) &&
                      (step_ff inside {S_DIVX, S_DIVY, S_XB, S_YB, S_ZB, S_NBX, S_NBY});
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_z_in = cur_z_ff;
      adv_in   = adv_ff;
      dxdy_in  = dxdy_ff;
      acc_in   = acc_ff;
      t_in     = t_ff;
      xq_in = xq_ff; xr_in = xr_ff; yq_in = yq_ff; yr_in = yr_ff;
      zq_in = zq_ff; zr_in = zr_ff; nbx_in = nbx_ff; nby_in = nby_ff;
      nn_in = nn_ff; bb_in = bb_ff; bn_in = bn_ff; off_in = off_ff;
      end_in = end_ff;
      rv_in = rv_ff; rb_in = rb_ff; ro_in = ro_ff;
      rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff; re_in = re_ff;

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_RUN;
               adv_in   = cmd.adv;
               end_in   = 1'b0;
               if (cmd.restart) begin
                  cur_x_in = '0;
                  cur_y_in = '0;
                  cur_z_in = '0;
                  step_in  = S_XB;
               end else begin
                  step_in  = S_DXDY;
               end
            end
         end
         ST_RUN: begin
            case (step_ff)
               S_DXDY: begin dxdy_in = AW'(mul_p); step_in = S_LZ; end
               S_LZ:   begin acc_in = LW'(mul_p); step_in = S_LY; end
               S_LY: begin
                  acc_in  = acc_ff + LW'(mul_p) + LW'(cur_x_ff) + LW'(adv_ff);
                  step_in = S_LAST;
               end
               S_LAST: begin
                  // Past the last node when the index reaches the node count.
                  if (PW'(acc_ff) >= mul_p) begin
                     cur_x_in = '0;
                     cur_y_in = '0;
                     cur_z_in = geom.dz;
                     end_in   = 1'b1;
                     bn_in    = '0;
                     off_in   = '0;
                     state_in = ST_OUT;
                  end else begin
                     step_in  = S_DIVX;
                  end
               end
               S_NN:  begin nn_in = AW'(mul_p); step_in = S_BNZ; end
               S_BNZ: begin bn_in = DW'(mul_p); step_in = S_BNY; end
               S_BNY: begin
                  bn_in   = bn_ff + DW'(mul_p) + DW'(xq_ff);
                  step_in = S_BB;
               end
               S_BB:  begin bb_in = AW'(mul_p); step_in = S_OFZ; end
               S_OFZ: begin off_in = DW'(mul_p); step_in = S_OFY; end
               S_OFY: begin
                  off_in   = off_ff + DW'(mul_p) + DW'(xr_ff);
                  state_in = ST_OUT;
               end
               default: state_in = ST_DIV;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_RUN;
               case (step_ff)
                  S_DIVX: begin cur_x_in = div_r; t_in = AW'(div_q); step_in = S_DIVY; end
                  S_DIVY: begin
                     cur_y_in = div_r;
                     cur_z_in = W'(div_q);
                     step_in  = S_XB;
                  end
                  S_XB:  begin xq_in = W'(div_q); xr_in = div_r; step_in = S_YB; end
                  S_YB:  begin yq_in = W'(div_q); yr_in = div_r; step_in = S_ZB; end
                  S_ZB:  begin zq_in = W'(div_q); zr_in = div_r; step_in = S_NBX; end
                  S_NBX: begin nbx_in = W'(div_q) + 1'b1; step_in = S_NBY; end
                  S_NBY: begin nby_in = W'(div_q) + 1'b1; step_in = S_NN; end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rb_in    = bn_ff;
               ro_in    = off_ff;
               rx_in    = cur_x_ff;
               ry_in    = cur_y_ff;
               rz_in    = cur_z_ff;
               re_in    = end_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= S_DXDY;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         cur_z_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         cur_z_ff <= cur_z_in;
         rv_ff    <= rv_in;
      end
      adv_ff <= adv_in; dxdy_ff <= dxdy_in; acc_ff <= acc_in; t_ff <= t_in;
      xq_ff <= xq_in; xr_ff <= xr_in; yq_ff <= yq_in; yr_ff <= yr_in;
      zq_ff <= zq_in; zr_ff <= zr_in; nbx_ff <= nbx_in; nby_ff <= nby_in;
      nn_ff <= nn_in; bb_ff <= bb_in; bn_ff <= bn_in; off_ff <= off_in;
      end_ff <= end_in;
      rb_ff <= rb_in; ro_ff <= ro_in; rx_ff <= rx_in; ry_ff <= ry_in;
      rz_ff <= rz_in; re_ff <= re_in;
   end

   assign rsp_valid  = rv_ff;
   assign rsp_brick  = rb_ff;
   assign rsp_offset = ro_ff;
   assign rsp_x      = rx_ff;
   assign rsp_y      = ry_ff;
   assign rsp_z      = rz_ff;
   assign rsp_end    = re_ff;
endmodule

@@ rtl/core/bvaw_checker.sv @@
// Port-level checks for the bricked volume address walker.
`timescale 1ns / 1ps
module bvaw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[81:0] == 82'd0)
      else $error("end result carries nonzero address or x/y");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[70:60] < 11'd1024 && rsp_tdata[81:71] < 11'd1024 &&
         rsp_tdata[92:82] < 11'd1024)
      else $error("in-volume result has a coordinate out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");
endmodule

bind bricked_volume_address_walker_unit bvaw_checker u_bvaw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
